// File: hdl/japanese_line_break_inserter_unit_assert.svh
// Assertion macros used by the checker file of the line break inserter.
`ifndef JAPANESE_LINE_BREAK_INSERTER_UNIT_ASSERT_SVH
`define JAPANESE_LINE_BREAK_INSERTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define JLBI_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jlbi assertion failed");

// next-cycle implication, disabled while reset is held
`define JLBI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jlbi assertion failed");

`endif

// File: hdl/jlbi_pkg.sv
`timescale 1ns / 1ps

package jlbi_pkg;

    localparam int unsigned CODE_W  = 21;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CODE_W-1:0] SEP_RESET = 21'h00200B;
    localparam logic [CODE_W-1:0] ZWSP      = 21'h00200B;
    localparam logic [CODE_W-1:0] TAB       = 21'h000009;

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        code_t held_code;
        code_t cur_code;
        logic  emit_held;
        logic  emit_sep;
        logic  emit_cur;
        logic  last;
        logic  bad;
    } cmd_t;

    function automatic logic is_gap(input code_t v);
        return (v == TAB) || (v == ZWSP);
    endfunction

    function automatic logic is_hira(input code_t v);
        return v inside {[21'h003040:21'h00309F]};
    endfunction

    function automatic logic is_kata(input code_t v);
        return v inside {[21'h0030A0:21'h0030FF]};
    endfunction

    function automatic logic is_ideograph(input code_t v);
        return v inside {[21'h004E00:21'h009FAF]};
    endfunction

    function automatic logic is_num(input code_t v);
        return v inside {[21'h000030:21'h000039], [21'h00FF10:21'h00FF19]};
    endfunction

    function automatic logic is_west(input code_t v);
        return v inside {[21'h000041:21'h00005A], [21'h00FF21:21'h00FF3A],
                         [21'h000061:21'h00007A], [21'h00FF41:21'h00FF5A]};
    endfunction

    function automatic logic is_brk_after(input code_t v);
        return v inside {
            21'h003000, 21'h003001, 21'h003002, 21'h003009, 21'h00300B, 21'h00300D,
            21'h00300F, 21'h003011, 21'h003015, 21'h003017, 21'h003019, 21'h00301B,
            21'h00FF01, 21'h00FF09, 21'h00FF1A};
    endfunction

    function automatic logic is_no_end(input code_t v);
        return v inside {
            21'h000028, 21'h00005B, 21'h00FF5B, 21'h003014, 21'h003008, 21'h00300A,
            21'h00300C, 21'h00300E, 21'h003010, 21'h003018, 21'h003016, 21'h00301D,
            21'h002018, 21'h00201C, 21'h00FF5F, 21'h0000AB};
    endfunction

    function automatic logic is_no_start(input code_t v);
        return v inside {
            21'h000029, 21'h00005D, 21'h00FF5D, 21'h003015, 21'h003009, 21'h00300B,
            21'h00300D, 21'h00300F, 21'h003011, 21'h003019, 21'h003017, 21'h00301F,
            21'h002019, 21'h00201D, 21'h00FF60, 21'h0000BB, 21'h0030FD, 21'h0030FE,
            21'h0030FC, 21'h0030A1, 21'h0030A3, 21'h0030A5, 21'h0030A7, 21'h0030A9,
            21'h0030C3, 21'h0030E3, 21'h0030E5, 21'h0030E7, 21'h0030EE, 21'h0030F5,
            21'h0030F6, 21'h003041, 21'h003043, 21'h003045, 21'h003047, 21'h003049,
            21'h003063, 21'h003083, 21'h003085, 21'h003087, 21'h00308E, 21'h003095,
            21'h003096, 21'h0031F0, 21'h0031F1, 21'h0031F2, 21'h0031F3, 21'h0031F4,
            21'h0031F5, 21'h0031F6, 21'h0031F7, 21'h0031F8, 21'h0031F9, 21'h0031FA,
            21'h0031FB, 21'h0031FC, 21'h0031FD, 21'h0031FE, 21'h0031FF, 21'h003005,
            21'h00303B, 21'h002010, 21'h0030A0, 21'h002013, 21'h00301C, 21'h00003F,
            21'h000021, 21'h00203C, 21'h002047, 21'h002048, 21'h002049, 21'h0030FB,
            21'h003001, 21'h00003A, 21'h00003B, 21'h00002C, 21'h003002, 21'h00002E};
    endfunction

    function automatic logic break_ok(input code_t a, input code_t b);
        logic r;
        r = 1'b0;
        if (is_gap(a) || is_gap(b)) begin
            r = 1'b0;
        end else if (is_no_end(a)) begin
            r = 1'b0;
        end else if (is_no_start(b)) begin
            r = 1'b0;
        end else if (is_brk_after(a)) begin
            r = 1'b1;
        end else if ((is_num(a) || is_west(a)) && (is_num(b) || is_west(b))) begin
            r = 1'b0;
        end else if (is_num(a)) begin
            r = is_hira(b) || is_kata(b) || is_west(b);
        end else if (is_hira(a)) begin
            r = is_ideograph(b) || is_kata(b) || is_west(b) || is_num(b);
        end else if (is_kata(a)) begin
            r = is_ideograph(b) || is_west(b) || is_num(b);
        end else if (is_ideograph(a)) begin
            r = is_kata(b) || is_west(b) || is_num(b);
        end else if (is_west(a)) begin
            r = is_kata(b) || is_ideograph(b) || is_num(b);
        end
        return r;
    endfunction

    // number of UTF-8 bytes minus one
    function automatic logic [1:0] code_len(input code_t v);
        logic [1:0] n;
        if (v < 21'h000080) begin
            n = 2'd0;
        end else if (v < 21'h000800) begin
            n = 2'd1;
        end else if (v < 21'h010000) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] code_byte(input code_t v, input logic [1:0] idx);
        logic [7:0] b;
        case (code_len(v))
            2'd0: begin
                b = {1'b0, v[6:0]};
            end
            2'd1: begin
                b = (idx == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, v[15:12]};
                    2'd1:    b = {2'b10, v[11:6]};
                    default: b = {2'b10, v[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, v[20:18]};
                    2'd1:    b = {2'b10, v[17:12]};
                    2'd2:    b = {2'b10, v[11:6]};
                    default: b = {2'b10, v[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// File: hdl/jlbi_front.sv
`timescale 1ns / 1ps

module jlbi_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_in_byte,
    input  logic            s_in_last,
    input  logic            q_full,
    output logic            q_push,
    output jlbi_pkg::cmd_t  q_cmd
);

    jlbi_pkg::code_t accum_reg, accum_next;
    logic [1:0]      rem_reg, rem_next;
    jlbi_pkg::code_t held_reg, held_next;
    logic            held_valid_reg, held_valid_next;

    logic            accept;
    logic            done;
    jlbi_pkg::code_t cp;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        accum_next      = accum_reg;
        rem_next        = rem_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        done            = 1'b0;
        cp              = '0;

        q_cmd           = '0;
        q_cmd.held_code = held_reg;
        q_cmd.last      = s_in_last;

        // decode
        if (rem_reg == 2'd0) begin
            if (!s_in_byte[7]) begin
                cp   = {13'd0, s_in_byte};
                done = 1'b1;
            end else if (s_in_byte[7:5] == 3'b110) begin
                accum_next = {16'd0, s_in_byte[4:0]};
                rem_next   = 2'd1;
            end else if (s_in_byte[7:4] == 4'b1110) begin
                accum_next = {17'd0, s_in_byte[3:0]};
                rem_next   = 2'd2;
            end else begin
                accum_next = {18'd0, s_in_byte[2:0]};
                rem_next   = 2'd3;
            end
        end else begin
            accum_next = {accum_reg[14:0], s_in_byte[5:0]};
            rem_next   = rem_reg - 2'd1;
            if (rem_reg == 2'd1) begin
                cp   = accum_next;
                done = 1'b1;
            end
        end

        q_cmd.cur_code = cp;

        // classify
        if (done) begin
            if (!held_valid_reg) begin
                if (s_in_last) begin
                    q_cmd.emit_cur = 1'b1;
                end else begin
                    held_next       = cp;
                    held_valid_next = 1'b1;
                end
            end else if (jlbi_pkg::is_gap(held_reg) && jlbi_pkg::is_gap(cp)) begin
                q_cmd.emit_cur = s_in_last;
            end else begin
                q_cmd.emit_held = 1'b1;
                q_cmd.emit_sep  = jlbi_pkg::break_ok(held_reg, cp);
                q_cmd.emit_cur  = s_in_last;
                held_next       = cp;
            end
        end else if (s_in_last && held_valid_reg) begin
            q_cmd.emit_held = 1'b1;
            q_cmd.bad       = 1'b1;
        end

        if (s_in_last) begin
            accum_next      = '0;
            rem_next        = 2'd0;
            held_next       = '0;
            held_valid_next = 1'b0;
        end

        q_push = accept && (q_cmd.emit_held || q_cmd.emit_sep || q_cmd.emit_cur);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg      <= '0;
            rem_reg        <= 2'd0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end else if (accept) begin
            accum_reg      <= accum_next;
            rem_reg        <= rem_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// File: hdl/jlbi_queue.sv
`timescale 1ns / 1ps

module jlbi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  jlbi_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output jlbi_pkg::cmd_t  head,
    output logic            empty
);

    jlbi_pkg::cmd_t                  mem_reg [jlbi_pkg::QDEPTH];
    logic [jlbi_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [jlbi_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [jlbi_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == jlbi_pkg::QCNT_W'(jlbi_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == jlbi_pkg::QPTR_W'(jlbi_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == jlbi_pkg::QPTR_W'(jlbi_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/jlbi_back.sv
`timescale 1ns / 1ps

module jlbi_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  jlbi_pkg::cmd_t  q_head,
    output logic            q_pop,
    input  jlbi_pkg::code_t sep_code,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last,
    output logic            m_bad_end
);

    logic [2:0]      done_reg, done_next;
    logic [1:0]      idx_reg, idx_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_byte_reg;
    logic            m_last_reg;
    logic            m_bad_reg;

    logic            load;
    logic [2:0]      en;
    logic [2:0]      pending;
    logic [2:0]      cur_oh;
    jlbi_pkg::code_t code;
    logic [1:0]      len;
    logic [7:0]      byte_val;
    logic            code_end;
    logic            final_byte;

    assign load = !q_empty && (!m_valid_reg || m_ready);

    always_comb begin
        en      = {q_head.emit_cur, q_head.emit_sep, q_head.emit_held};
        pending = en & ~done_reg;
        cur_oh  = pending & (~pending + 3'd1);
        case (cur_oh)
            3'b001:  code = q_head.held_code;
            3'b010:  code = sep_code;
            default: code = q_head.cur_code;
        endcase
        len        = jlbi_pkg::code_len(code);
        byte_val   = jlbi_pkg::code_byte(code, idx_reg);
        code_end   = (idx_reg == len);
        final_byte = code_end && ((pending & ~cur_oh) == 3'b000);
    end

    always_comb begin
        done_next    = done_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        q_pop        = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            if (final_byte) begin
                done_next = 3'b000;
                idx_next  = 2'd0;
                q_pop     = 1'b1;
            end else if (code_end) begin
                done_next = done_reg | cur_oh;
                idx_next  = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= 3'b000;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_reg <= byte_val;
            m_last_reg <= q_head.last && final_byte;
            m_bad_reg  <= q_head.bad && final_byte;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;
    assign m_bad_end  = m_bad_reg;

endmodule

// File: hdl/japanese_line_break_inserter_unit.sv
`timescale 1ns / 1ps

// Kinsoku line break inserter: takes a UTF-8 string one byte per item (s_in_last on the
// final byte) and returns it one byte per item with the separator code point (cfg_wr_data,
// reset U+200B) inserted wherever the Japanese kinsoku and script-class rules allow a break;
// runs of tabs and zero-width spaces collapse to one member. The decoder takes one input
// item per cycle while the queue is not full, and passes a command through a two-entry
// queue to the encoder, which writes one output byte per cycle while a command waits and
// m_ready does not stall it. An input item releases 0 to 12 output bytes.
// Output lags the input by one code point, and m_bad_end on the final byte marks a string
// cut off inside a code point. Write cfg_wr_en only while the block is idle.

module japanese_line_break_inserter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [20:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    output logic        m_bad_end
);

    jlbi_pkg::code_t sep_reg;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    jlbi_pkg::cmd_t  q_cmd;
    jlbi_pkg::cmd_t  q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= jlbi_pkg::SEP_RESET;
        end else if (cfg_wr_en) begin
            sep_reg <= cfg_wr_data;
        end
    end

    jlbi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    jlbi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    jlbi_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .sep_code   (sep_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .m_bad_end  (m_bad_end)
    );

endmodule

// File: hdl/jlbi_checker.sv
`timescale 1ns / 1ps

`include "japanese_line_break_inserter_unit_assert.svh"

module jlbi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_out_last,
    input logic        m_bad_end
);

    logic [9:0] out_word;
    logic       lead_byte;

    assign out_word  = {m_out_byte, m_out_last, m_bad_end};
    assign lead_byte = (m_out_byte[7:6] == 2'b11);

    `JLBI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `JLBI_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(out_word))
    `JLBI_ASSERT_NOW(a_bad_on_last, aclk, aresetn, m_valid && m_bad_end, m_out_last)
    `JLBI_ASSERT_NOW(a_lead_not_last, aclk, aresetn, m_valid && lead_byte, !m_out_last)

endmodule

bind japanese_line_break_inserter_unit jlbi_checker u_jlbi_checker (.*);

// File: verif/tb_japanese_line_break_inserter_unit.sv
`timescale 1ns / 1ps

module tb_japanese_line_break_inserter_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 8;

    localparam logic [20:0] CP_TAB       = jlbi_pkg::TAB;
    localparam logic [20:0] CP_ZWSP      = jlbi_pkg::ZWSP;
    localparam logic [20:0] CP_SEP_RESET = jlbi_pkg::SEP_RESET;

    typedef enum logic [2:0] {SC_OTHER, SC_NUM, SC_WEST, SC_HIRA, SC_KATA, SC_KANJI} script_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } out_beat_t;

    typedef struct packed {
        logic        cfg_en;
        logic [20:0] cfg_val;
        logic [7:0]  data;
        logic        last;
        logic        use_pred;
        logic [2:0]  typed_n;
        logic [31:0] typed_bytes;
        logic        typed_bad;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [20:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_out_last;
    logic        m_bad_end;

    logic [20:0] sep_cfg;
    logic [20:0] dec_acc;
    logic [1:0]  dec_left;
    logic [20:0] hold_cp;
    logic        hold_ok;

    out_beat_t   step_out[$];
    out_beat_t   expected_bytes[$];
    logic [7:0]  str_q[$];
    dir_row_t    dir_rows[$];
    dir_row_t    row;
    out_beat_t   got;
    out_beat_t   want;

    int mismatches  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int idle_odds   = 6;
    bit quiet       = 1'b0;

    japanese_line_break_inserter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .m_bad_end   (m_bad_end)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit gap_char(input logic [20:0] v);
        return (v == CP_TAB) || (v == CP_ZWSP);
    endfunction

    function automatic script_t script_of(input logic [20:0] v);
        if ((v >= 21'h30 && v <= 21'h39) || (v >= 21'hFF10 && v <= 21'hFF19)) begin
            return SC_NUM;
        end
        if ((v >= 21'h41 && v <= 21'h5A) || (v >= 21'h61 && v <= 21'h7A) ||
            (v >= 21'hFF21 && v <= 21'hFF3A) || (v >= 21'hFF41 && v <= 21'hFF5A)) begin
            return SC_WEST;
        end
        if (v >= 21'h3040 && v <= 21'h309F) begin
            return SC_HIRA;
        end
        if (v >= 21'h30A0 && v <= 21'h30FF) begin
            return SC_KATA;
        end
        if (v >= 21'h4E00 && v <= 21'h9FAF) begin
            return SC_KANJI;
        end
        return SC_OTHER;
    endfunction

    function automatic bit break_after(input logic [20:0] v);
        case (v)
            21'h3000, 21'h3001, 21'h3002, 21'h3009, 21'h300B, 21'h300D, 21'h300F,
            21'h3011, 21'h3015, 21'h3017, 21'h3019, 21'h301B, 21'hFF01, 21'hFF09,
            21'hFF1A: return 1'b1;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic bit no_line_end(input logic [20:0] v);
        case (v)
            21'h0028, 21'h005B, 21'hFF5B, 21'h3014, 21'h3008, 21'h300A, 21'h300C,
            21'h300E, 21'h3010, 21'h3018, 21'h3016, 21'h301D, 21'h2018, 21'h201C,
            21'hFF5F, 21'h00AB: return 1'b1;
            default:            return 1'b0;
        endcase
    endfunction

    function automatic bit no_line_start(input logic [20:0] v);
        if (v >= 21'h31F0 && v <= 21'h31FF) begin
            return 1'b1;
        end
        case (v)
            21'h0029, 21'h005D, 21'hFF5D, 21'h3015, 21'h3009, 21'h300B, 21'h300D,
            21'h300F, 21'h3011, 21'h3019, 21'h3017, 21'h301F, 21'h2019, 21'h201D,
            21'hFF60, 21'h00BB, 21'h30FD, 21'h30FE, 21'h30FC, 21'h30A1, 21'h30A3,
            21'h30A5, 21'h30A7, 21'h30A9, 21'h30C3, 21'h30E3, 21'h30E5, 21'h30E7,
            21'h30EE, 21'h30F5, 21'h30F6, 21'h3041, 21'h3043, 21'h3045, 21'h3047,
            21'h3049, 21'h3063, 21'h3083, 21'h3085, 21'h3087, 21'h308E, 21'h3095,
            21'h3096, 21'h3005, 21'h303B, 21'h2010, 21'h30A0, 21'h2013, 21'h301C,
            21'h003F, 21'h0021, 21'h203C, 21'h2047, 21'h2048, 21'h2049, 21'h30FB,
            21'h3001, 21'h003A, 21'h003B, 21'h002C, 21'h3002, 21'h002E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit may_break(input logic [20:0] a, input logic [20:0] b);
        script_t sa;
        script_t sb;
        sa = script_of(a);
        sb = script_of(b);
        if (gap_char(a) || gap_char(b) || no_line_end(a) || no_line_start(b)) begin
            return 1'b0;
        end
        if (break_after(a)) begin
            return 1'b1;
        end
        case (sa)
            SC_NUM:   return sb == SC_HIRA || sb == SC_KATA;
            SC_WEST:  return sb == SC_KATA || sb == SC_KANJI;
            SC_HIRA:  return sb == SC_KANJI || sb == SC_KATA || sb == SC_WEST || sb == SC_NUM;
            SC_KATA:  return sb == SC_KANJI || sb == SC_WEST || sb == SC_NUM;
            SC_KANJI: return sb == SC_KATA || sb == SC_WEST || sb == SC_NUM;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic void append_utf8(input logic [20:0] v);
        if (v < 21'h80) begin
            step_out.push_back({v[7:0], 2'b00});
        end else if (v < 21'h800) begin
            step_out.push_back({3'b110, v[10:6], 2'b00});
            step_out.push_back({2'b10, v[5:0], 2'b00});
        end else if (v < 21'h10000) begin
            step_out.push_back({4'b1110, v[15:12], 2'b00});
            step_out.push_back({2'b10, v[11:6], 2'b00});
            step_out.push_back({2'b10, v[5:0], 2'b00});
        end else begin
            step_out.push_back({5'b11110, v[20:18], 2'b00});
            step_out.push_back({2'b10, v[17:12], 2'b00});
            step_out.push_back({2'b10, v[11:6], 2'b00});
            step_out.push_back({2'b10, v[5:0], 2'b00});
        end
    endfunction

    function automatic void predict_out_bytes(input logic [7:0] b, input logic last);
        logic [20:0] cp;
        logic        done;
        out_beat_t   tail;
        cp   = '0;
        done = 1'b0;
        step_out.delete();
        if (dec_left == 2'd0) begin
            if (!b[7]) begin
                cp   = {13'd0, b};
                done = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                dec_acc  = {16'd0, b[4:0]};
                dec_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                dec_acc  = {17'd0, b[3:0]};
                dec_left = 2'd2;
            end else begin
                dec_acc  = {18'd0, b[2:0]};
                dec_left = 2'd3;
            end
        end else begin
            dec_acc  = {dec_acc[14:0], b[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0) begin
                cp   = dec_acc;
                done = 1'b1;
            end
        end
        if (done) begin
            if (!hold_ok) begin
                if (last) begin
                    append_utf8(cp);
                end else begin
                    hold_cp = cp;
                    hold_ok = 1'b1;
                end
            end else if (gap_char(hold_cp) && gap_char(cp)) begin
                if (last) begin
                    append_utf8(cp);
                end
            end else begin
                append_utf8(hold_cp);
                if (may_break(hold_cp, cp)) begin
                    append_utf8(sep_cfg);
                end
                if (last) begin
                    append_utf8(cp);
                end else begin
                    hold_cp = cp;
                end
            end
        end else if (last && hold_ok) begin
            append_utf8(hold_cp);
        end
        if (last) begin
            if (step_out.size() > 0) begin
                tail      = step_out.pop_back();
                tail.last = 1'b1;
                tail.bad  = !done;
                step_out.push_back(tail);
            end
            dec_acc  = '0;
            dec_left = '0;
            hold_cp  = '0;
            hold_ok  = 1'b0;
        end
    endfunction

    function automatic logic [7:0] cont_byte(input logic [5:0] x);
        logic [1:0] top;
        top = 2'b10;
        if ($urandom_range(0, 7) == 0) begin
            top = 2'($urandom_range(0, 3));
        end
        return {top, x};
    endfunction

    function automatic void encode_cp(input logic [20:0] v);
        int         len;
        logic [2:0] r3;
        if (v < 21'h80) begin
            len = 1;
        end else if (v < 21'h800) begin
            len = 2;
        end else if (v < 21'h10000) begin
            len = 3;
        end else begin
            len = 4;
        end
        // occasionally use a longer form than needed
        if (len < 4 && $urandom_range(0, 9) == 0) begin
            len = len + 1;
        end
        r3 = 3'($urandom_range(0, 7));
        case (len)
            1: begin
                str_q.push_back({1'b0, v[6:0]});
            end
            2: begin
                str_q.push_back({3'b110, v[10:6]});
                str_q.push_back(cont_byte(v[5:0]));
            end
            3: begin
                str_q.push_back({4'b1110, v[15:12]});
                str_q.push_back(cont_byte(v[11:6]));
                str_q.push_back(cont_byte(v[5:0]));
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       str_q.push_back({5'b11111, v[20:18]});
                    1:       str_q.push_back({2'b10, r3, v[20:18]});
                    default: str_q.push_back({5'b11110, v[20:18]});
                endcase
                str_q.push_back(cont_byte(v[17:12]));
                str_q.push_back(cont_byte(v[11:6]));
                str_q.push_back(cont_byte(v[5:0]));
            end
        endcase
    endfunction

    function automatic logic [20:0] pick_code();
        logic [20:0] v;
        case ($urandom_range(0, 11))
            0:  v = 21'($urandom_range(21'h20, 21'h7E));
            1:  v = 21'($urandom_range(21'h30, 21'h39));
            2:  v = 21'($urandom_range(21'h3040, 21'h309F));
            3:  v = 21'($urandom_range(21'h30A0, 21'h30FF));
            4:  v = 21'($urandom_range(21'h4E00, 21'h9FAF));
            5:  v = 21'($urandom_range(21'hFF10, 21'hFF5F));
            6:  v = ($urandom_range(0, 1) == 0) ? CP_TAB : CP_ZWSP;
            7: begin
                case ($urandom_range(0, 15))
                    0:       v = 21'h3001;
                    1:       v = 21'h3002;
                    2:       v = 21'h300C;
                    3:       v = 21'h300D;
                    4:       v = 21'h0028;
                    5:       v = 21'h0029;
                    6:       v = 21'hFF01;
                    7:       v = 21'hFF5B;
                    8:       v = 21'h00AB;
                    9:       v = 21'h00BB;
                    10:      v = 21'h2018;
                    11:      v = 21'h31F5;
                    12:      v = 21'h3000;
                    13:      v = 21'hFF1A;
                    14:      v = 21'h30FC;
                    default: v = 21'h002E;
                endcase
            end
            8:  v = 21'($urandom_range(21'h80, 21'h7FF));
            9:  v = 21'($urandom_range(21'h10000, 21'h1FFFFF));
            10: v = 21'($urandom_range(21'h800, 21'hFFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = 21'h000000;
                    1:       v = 21'h00007F;
                    2:       v = 21'h000080;
                    3:       v = 21'h0007FF;
                    4:       v = 21'h00FFFF;
                    default: v = 21'h1FFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_row(input logic cfg_en, input logic [20:0] cfg_val,
                           input logic [7:0] data, input logic last, input logic use_pred,
                           input logic [2:0] typed_n, input logic [31:0] typed_bytes,
                           input logic typed_bad);
        dir_row_t r;
        r.cfg_en      = cfg_en;
        r.cfg_val     = cfg_val;
        r.data        = data;
        r.last        = last;
        r.use_pred    = use_pred;
        r.typed_n     = typed_n;
        r.typed_bytes = typed_bytes;
        r.typed_bad   = typed_bad;
        dir_rows.push_back(r);
    endtask

    task automatic send_item(input logic [7:0] b, input logic last, input logic use_pred);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, idle_odds) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        predict_out_bytes(b, last);
        if (use_pred) begin
            foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
        end
    endtask

    task automatic write_separator(input logic [20:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        // drain items that release nothing
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        sep_cfg = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && aresetn && $urandom_range(0, idle_odds) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_out_last, m_bad_end};
                if (expected_bytes.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected output: byte %h last %b bad_end %b",
                                 got.data, got.last, got.bad);
                    end
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.bad !== want.bad) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.data, want.last, want.bad,
                                     got.data, got.last, got.bad);
                        end
                        mismatches++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL japanese_line_break_inserter_unit");
                $finish;
            end
        end
    end

    initial begin
        int          k;
        int          ph;
        int          sent;
        int          kind;
        int          ncp;
        int          before_len;
        int          drop;
        logic        fin;
        logic [20:0] sep;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_in_byte   = '0;
        s_in_last   = 1'b0;
        sep_cfg     = CP_SEP_RESET;
        dec_acc     = '0;
        dec_left    = '0;
        hold_cp     = '0;
        hold_ok     = 1'b0;

        // single-byte strings and extremes
        add_row(1'b0, 21'h0, 8'h41, 1'b1, 1'b0, 3'd1, 32'h41000000, 1'b0);
        add_row(1'b0, 21'h0, 8'h00, 1'b1, 1'b0, 3'd1, 32'h00000000, 1'b0);
        add_row(1'b0, 21'h0, 8'hFF, 1'b1, 1'b0, 3'd0, 32'h00000000, 1'b0);
        add_row(1'b0, 21'h0, 8'h80, 1'b1, 1'b0, 3'd0, 32'h00000000, 1'b0);
        // cut off inside a code point after a held one
        add_row(1'b0, 21'h0, 8'h7F, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b0);
        add_row(1'b0, 21'h0, 8'hE3, 1'b1, 1'b0, 3'd1, 32'h7F000000, 1'b1);
        // overlong form comes out shortest
        add_row(1'b0, 21'h0, 8'hC1, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b0);
        add_row(1'b0, 21'h0, 8'h81, 1'b1, 1'b0, 3'd1, 32'h41000000, 1'b0);
        // kanji then katakana
        add_row(1'b0, 21'h0, 8'hE6, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h97, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'hA5, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'hE3, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h82, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'hA2, 1'b1, 1'b1, 3'd0, 32'h0, 1'b0);
        // tab and zero-width space collapse
        add_row(1'b0, 21'h0, 8'h09, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'hE2, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h80, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h8B, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h41, 1'b1, 1'b1, 3'd0, 32'h0, 1'b0);
        // gap run reaching the end keeps its last member
        add_row(1'b0, 21'h0, 8'h09, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b0);
        add_row(1'b0, 21'h0, 8'h09, 1'b1, 1'b0, 3'd1, 32'h09000000, 1'b0);
        // separator change in mid string
        add_row(1'b0, 21'h0, 8'h31, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b1, 21'h1FFFFF, 8'hE3, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h81, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0);
        add_row(1'b0, 21'h0, 8'h82, 1'b1, 1'b1, 3'd0, 32'h0, 1'b0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.cfg_en) begin
                write_separator(row.cfg_val);
            end
            send_item(row.data, row.last, row.use_pred);
            for (k = 0; k < row.typed_n; k++) begin
                fin = row.last && (k == row.typed_n - 1);
                expected_bytes.push_back({row.typed_bytes[31 - 8 * k -: 8], fin,
                                          fin & row.typed_bad});
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       sep = 21'h000000;
                1:       sep = 21'h1FFFFF;
                2:       sep = 21'h00007F;
                3:       sep = 21'h000080;
                4:       sep = 21'h0007FF;
                5:       sep = 21'h000800;
                6:       sep = 21'h00FFFF;
                7:       sep = 21'h010000;
                8:       sep = 21'($urandom_range(0, 21'h1FFFFF));
                default: sep = CP_SEP_RESET;
            endcase
            write_separator(sep);
            quiet     = (ph == NUM_PHASES - 1);
            idle_odds = $urandom_range(2, 12);
            sent      = 0;
            while (sent < PHASE_ITEMS) begin
                str_q.delete();
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    ncp = $urandom_range(1, 6);
                    repeat (ncp) str_q.push_back(8'($urandom_range(0, 255)));
                end else if (kind == 1) begin
                    ncp = $urandom_range(0, 4);
                    repeat (ncp) encode_cp(pick_code());
                    before_len = str_q.size();
                    encode_cp(21'($urandom_range(21'h80, 21'h1FFFFF)));
                    drop = $urandom_range(1, str_q.size() - before_len - 1);
                    repeat (drop) str_q.delete(str_q.size() - 1);
                end else begin
                    ncp = $urandom_range(1, 6);
                    repeat (ncp) encode_cp(pick_code());
                end
                foreach (str_q[i]) send_item(str_q[i], i == str_q.size() - 1, 1'b1);
                sent += str_q.size();
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS japanese_line_break_inserter_unit");
        end else begin
            $display("FAIL japanese_line_break_inserter_unit");
        end
        $finish;
    end

endmodule
